// ===== rtl/btpa_pkg.sv =====
// ----------------------------------------------------------------------------
// btpa_pkg
// Shared widths, operation codes and helper functions of the buddy page
// allocator.
// ----------------------------------------------------------------------------
package btpa_pkg;

  // Tree size: 2^LOG_PAGES pages
  localparam int LOG_PAGES  = 10;

  // Field widths of the request and response items
  localparam int FUNC_W     = 2;
  localparam int PAGES_W    = LOG_PAGES + 1;
  localparam int OFFS_W     = LOG_PAGES;
  localparam int CNT_W      = 11;
  localparam int STAT_W     = 1;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Width of a block size given as log2 pages (covers up to 2^31)
  localparam int SLOG_W = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX   = 11'd2047;
  localparam logic [CNT_W-1:0] MANAGED_RST = 11'd1024;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_INIT  = 2'd2,
    FN_NOP   = 2'd3
  } btpa_func_t;

  // Operations of the shared node unit
  typedef enum logic [1:0] {
    NU_FIT   = 2'd0,
    NU_MAX   = 2'd1,
    NU_MERGE = 2'd2
  } btpa_nu_op_t;

  typedef struct packed {
    btpa_nu_op_t         op;
    logic [SLOG_W-1:0]   slog;
  } btpa_nu_ctrl_t;

  // Smallest k with 2^k >= v, for v >= 1
  function automatic logic [SLOG_W-1:0] ceil_log2(input logic [PAGES_W-1:0] v);
    logic [PAGES_W-1:0] vm1;
    logic [SLOG_W-1:0]  r;
    vm1 = v - PAGES_W'(1);
    r   = '0;
    for (int i = 0; i < PAGES_W; i++) begin
      if (vm1[i]) begin
        r = SLOG_W'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/buddy_tree_page_allocator_top.sv =====
// An allocate reads the tree from the root down to the block level and then
// updates its ancestors on the way back up; a failed allocate stops at the root.
// A free marks its block and updates its ancestors; init sweeps the whole tree.
// The next request is taken in the cycle after the response is loaded; one tree
// level costs one RAM access. Reset: synchronous; the tree RAM is refilled by a
// clearing pass over every node, during which s_tready stays low.
// ----------------------------------------------------------------------------
// buddy_tree_page_allocator_top
// Buddy page allocator over a longest-free-block tree held in RAM. A sequencer
// walks the tree one level per cycle, down for allocate and up for updates.
// ----------------------------------------------------------------------------
module buddy_tree_page_allocator_top (
  input  logic                            clk,
  input  logic                            rst,
  // Request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [btpa_pkg::IN_DATA_W-1:0]  s_tdata,   // [10:0] pages, [20:11] offset
  input  logic [btpa_pkg::FUNC_W-1:0]     s_tuser,   // [1:0] func
  // Response stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [btpa_pkg::OUT_DATA_W-1:0] m_tdata,   // [9:0] block_offset, [20:10] free count
  output logic [btpa_pkg::STAT_W-1:0]     m_tuser,   // [0] status
  // Configuration
  input  logic                            cfg_wr_en,
  input  logic [btpa_pkg::CNT_W-1:0]      cfg_wr_data
);
  import btpa_pkg::*;

  localparam int VAL_W  = LOG_PAGES + 1;
  localparam int ADDR_W = LOG_PAGES + 1;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int WIDE_W = ((VAL_W > CNT_W) ? VAL_W : CNT_W) + 1;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PREP  = 8'b0000_0010,
    ST_CHECK = 8'b0000_0100,
    ST_DOWN  = 8'b0000_1000,
    ST_MARK  = 8'b0001_0000,
    ST_UP    = 8'b0010_0000,
    ST_SWEEP = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t              state;
  btpa_func_t          func_r;
  logic [PAGES_W-1:0]  pages_r;
  logic [OFFS_W-1:0]   offs_r;
  logic [SLOG_W-1:0]   req_slog;
  logic [SLOG_W-1:0]   cur_slog;
  logic [ADDR_W-1:0]   node;
  logic [VAL_W-1:0]    wval;
  logic [CNT_W-1:0]    fcount;
  logic [CNT_W-1:0]    mpages;
  logic                init_pend;
  logic                res_status;
  logic [OFFS_W-1:0]   res_blk;
  logic                m_valid;
  logic                m_status;
  logic [OFFS_W-1:0]   m_blk;
  logic [CNT_W-1:0]    m_free;

  // Datapath signals
  logic [PAGES_W-1:0]     req;
  logic [SLOG_W-1:0]      rlog;
  logic [SLOG_W-1:0]      free_slog;
  logic [ADDR_W-1:0]      leaf;
  logic [ADDR_W-1:0]      child;
  logic [ADDR_W-1:0]      parent;
  logic [ADDR_W-1:0]      node_inc;
  logic [WIDE_W-1:0]      s_wide;
  logic [WIDE_W-1:0]      fc_wide;
  logic [WIDE_W-1:0]      fc_sum;
  logic [2*LOG_PAGES:0]   blk_wide;
  logic [LOG_PAGES-1:0]   blk_pos;
  logic                   alloc_fail;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [VAL_W-1:0]       ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [VAL_W-1:0]       ram_rdata;
  btpa_nu_ctrl_t          nu_ctrl;
  logic                   nu_fit;
  logic [VAL_W-1:0]       nu_val;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = m_valid;
  assign m_tuser  = m_status;
  assign m_tdata  = {(OUT_DATA_W - CNT_W - OFFS_W)'(0), m_free, m_blk};

  // Request size and tree positions
  assign req       = (pages_r == '0) ? PAGES_W'(1) : pages_r;
  assign rlog      = ceil_log2(req);
  assign free_slog = (rlog > SLOG_W'(LOG_PAGES)) ? SLOG_W'(LOG_PAGES) : rlog;
  assign leaf      = {1'b1, LOG_PAGES'(offs_r)};
  assign child     = {node[ADDR_W-2:0], ~nu_fit};
  assign parent    = {1'b0, node[ADDR_W-1:1]};
  assign node_inc  = node + ADDR_W'(1);

  // Free count arithmetic
  assign s_wide   = WIDE_W'(1) << req_slog;
  assign fc_wide  = WIDE_W'(fcount);
  assign fc_sum   = fc_wide + s_wide;
  assign blk_wide = (2 * LOG_PAGES + 1)'(node) << req_slog;
  assign blk_pos  = blk_wide[LOG_PAGES-1:0];

  assign alloc_fail = (req > fcount) || (req_slog > SLOG_W'(LOG_PAGES)) || !nu_fit;

  // Drive the node unit
  always_comb begin
    nu_ctrl.op   = NU_FIT;
    nu_ctrl.slog = req_slog;
    if (state == ST_UP) begin
      nu_ctrl.op   = (func_r == FN_ALLOC) ? NU_MAX : NU_MERGE;
      nu_ctrl.slog = cur_slog + SLOG_W'(1);
    end
  end

  // Select RAM addresses and write data
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node;
    ram_wdata = wval;
    ram_raddr = '0;
    case (state)
      ST_PREP: begin
        ram_raddr = ADDR_W'(1);
      end
      ST_CHECK: begin
        ram_raddr = {node[ADDR_W-2:0], 1'b0};
      end
      ST_DOWN: begin
        ram_raddr = {child[ADDR_W-2:0], 1'b0};
      end
      ST_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = (func_r == FN_ALLOC) ? '0 : s_wide[VAL_W-1:0];
        ram_raddr = {node[ADDR_W-1:1], ~node[0]};
      end
      ST_UP: begin
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = nu_val;
        ram_raddr = {parent[ADDR_W-1:1], ~parent[0]};
      end
      ST_SWEEP: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  btpa_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_tree_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  btpa_node_unit u_node_unit (
    .ctrl    (nu_ctrl),
    .rd_val  (ram_rdata),
    .cur_val (wval),
    .fit     (nu_fit),
    .res_val (nu_val)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      mpages <= MANAGED_RST;
    end else if (cfg_wr_en) begin
      mpages <= cfg_wr_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      node      <= ADDR_W'(1);
      wval      <= VAL_W'(1) << LOG_PAGES;
      fcount    <= MANAGED_RST;
      init_pend <= 1'b0;
      m_valid   <= 1'b0;
    end else begin
      // Drop the response once taken, unless a new one is loaded now
      if (m_valid && m_tready && state != ST_DONE) begin
        m_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            func_r  <= btpa_func_t'(s_tuser);
            pages_r <= s_tdata[PAGES_W-1:0];
            offs_r  <= s_tdata[PAGES_W+OFFS_W-1:PAGES_W];
            state   <= ST_PREP;
          end
        end
        ST_PREP: begin
          res_status <= 1'b0;
          res_blk    <= '0;
          case (func_r)
            FN_ALLOC: begin
              req_slog <= rlog;
              cur_slog <= SLOG_W'(LOG_PAGES);
              node     <= ADDR_W'(1);
              state    <= ST_CHECK;
            end
            FN_FREE: begin
              req_slog <= free_slog;
              cur_slog <= free_slog;
              node     <= leaf >> free_slog;
              state    <= ST_MARK;
            end
            FN_INIT: begin
              fcount    <= mpages;
              node      <= ADDR_W'(1);
              wval      <= VAL_W'(1) << LOG_PAGES;
              init_pend <= 1'b1;
              state     <= ST_SWEEP;
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_CHECK: begin
          // Reject on free count, oversize or root too small
          if (alloc_fail) begin
            res_status <= 1'b1;
            state      <= ST_DONE;
          end else if (req_slog == cur_slog) begin
            state <= ST_MARK;
          end else begin
            state <= ST_DOWN;
          end
        end
        ST_DOWN: begin
          // Take the left child when it fits
          node     <= child;
          cur_slog <= cur_slog - SLOG_W'(1);
          if (cur_slog - SLOG_W'(1) == req_slog) begin
            state <= ST_MARK;
          end
        end
        ST_MARK: begin
          if (func_r == FN_ALLOC) begin
            wval    <= '0;
            res_blk <= OFFS_W'(blk_pos);
            fcount  <= (fc_wide > s_wide) ? CNT_W'(fc_wide - s_wide) : '0;
          end else begin
            wval   <= s_wide[VAL_W-1:0];
            fcount <= (fc_sum > WIDE_W'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(fc_sum);
          end
          state <= (node == ADDR_W'(1)) ? ST_DONE : ST_UP;
        end
        ST_UP: begin
          // Refresh one ancestor per cycle
          node     <= parent;
          wval     <= nu_val;
          cur_slog <= cur_slog + SLOG_W'(1);
          if (parent == ADDR_W'(1)) begin
            state <= ST_DONE;
          end
        end
        ST_SWEEP: begin
          // Refill every node with its subtree size
          if (node == '1) begin
            init_pend <= 1'b0;
            state     <= init_pend ? ST_DONE : ST_IDLE;
          end else begin
            node <= node_inc;
            if ((node_inc & node) == '0) begin
              wval <= wval >> 1;
            end
          end
        end
        ST_DONE: begin
          // Hold until the response register is free
          if (!m_valid || m_tready) begin
            m_valid  <= 1'b1;
            m_status <= res_status;
            m_blk    <= res_blk;
            m_free   <= fcount;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Assertions
  a_mark_level: assert property (@(posedge clk) disable iff (rst)
    state == ST_MARK |-> req_slog == cur_slog)
    else $error("marked node is not at the requested block level");

  a_down_node: assert property (@(posedge clk) disable iff (rst)
    state == ST_DOWN |-> node != '0 && cur_slog > req_slog)
    else $error("descent past the requested level");

  a_up_below_root: assert property (@(posedge clk) disable iff (rst)
    state == ST_UP |-> cur_slog < SLOG_W'(LOG_PAGES) && node != ADDR_W'(1))
    else $error("ancestor update above the root");

  a_fail_no_offset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[OFFS_W-1:0] == '0)
    else $error("failed allocation reports a block offset");

  a_no_early_resp: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("response raised in the cycle after a request");

endmodule

// ===== rtl/btpa_ram.sv =====
// ----------------------------------------------------------------------------
// btpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module btpa_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/btpa_node_unit.sv =====
// ----------------------------------------------------------------------------
// btpa_node_unit
// Shared compare and update unit for tree nodes: fit test against a block
// size, maximum of two children, and buddy merge.
// ----------------------------------------------------------------------------
module btpa_node_unit (
  input  btpa_pkg::btpa_nu_ctrl_t          ctrl,
  input  logic [btpa_pkg::LOG_PAGES:0]     rd_val,
  input  logic [btpa_pkg::LOG_PAGES:0]     cur_val,
  output logic                             fit,
  output logic [btpa_pkg::LOG_PAGES:0]     res_val
);
  import btpa_pkg::*;

  localparam int VAL_W = LOG_PAGES + 1;

  logic [VAL_W:0]   ext_rd;
  logic [VAL_W:0]   ext_cur;
  logic [VAL_W:0]   sz;
  logic [VAL_W:0]   sum;
  logic [VAL_W-1:0] big;

  assign ext_rd  = {1'b0, rd_val};
  assign ext_cur = {1'b0, cur_val};
  assign sz      = (VAL_W + 1)'(1) << ctrl.slog;
  assign sum     = ext_rd + ext_cur;
  assign big     = (rd_val > cur_val) ? rd_val : cur_val;

  // Select the operation
  always_comb begin
    fit     = 1'b0;
    res_val = cur_val;
    case (ctrl.op)
      NU_FIT: begin
        fit     = (ext_rd >= sz);
        res_val = rd_val;
      end
      NU_MAX: begin
        res_val = big;
      end
      NU_MERGE: begin
        res_val = (sum == sz) ? sz[VAL_W-1:0] : big;
      end
      default: begin
        fit     = 1'b0;
        res_val = cur_val;
      end
    endcase
  end

endmodule
